// ===== rtl/core/h3j_pkg.sv =====
// Shared types and constants for the 3D Jacobi stencil unit.
`default_nettype none

package h3j_pkg;

    // Fixed field widths
    localparam int VALUE_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int GAIN_BITS      = 18;
    localparam int COORD_BITS     = 5;
    localparam int SIZE_BITS      = 5;
    localparam int SWEEP_BITS     = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;

    // Datapath widths: six-term neighbor sum, product, rounded accumulator
    localparam int SUM_BITS  = VALUE_BITS + 3;
    localparam int PROD_BITS = SUM_BITS + GAIN_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_X         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Y         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Z         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEIGHBOUR_GAIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_GAIN    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_COUNT    = 3'd5;

    // Register reset values
    localparam logic [SIZE_BITS-1:0]         SIZE_RST      = 5'd30;
    localparam logic signed [GAIN_BITS-1:0]  NB_GAIN_RST   = 18'sd0;
    localparam logic signed [GAIN_BITS-1:0]  CTR_GAIN_RST  = 18'sd65536;
    localparam logic [SWEEP_BITS-1:0]        SWEEP_RST     = 16'd1;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t                     req_type;
        logic [COORD_BITS-1:0]         coord_x;
        logic [COORD_BITS-1:0]         coord_y;
        logic [COORD_BITS-1:0]         coord_z;
        logic signed [VALUE_BITS-1:0]  cell_value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  read_value;
        logic                          status;
        logic                          run_done;
    } resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_RDATA,
        ST_CELL,
        ST_SWAP,
        ST_RESP
    } state_t;

    // Per-cell sequence: seven reads, two multiplies, accumulate, write back
    typedef enum logic [3:0] {
        PH_RD_C,
        PH_RD_XM,
        PH_RD_XP,
        PH_RD_YM,
        PH_RD_YP,
        PH_RD_ZM,
        PH_RD_ZP,
        PH_LAST_NB,
        PH_MUL_C,
        PH_MUL_N,
        PH_ACC,
        PH_WB
    } phase_t;

    typedef struct packed {
        logic load_centre;
        logic add_nb;
        logic mul_en;
        logic mul_nb;
        logic acc_init;
        logic acc_add;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/h3j_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module h3j_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/h3j_alu.sv =====
// Shared stencil arithmetic: neighbor sum, one multiplier, round and saturate.
`default_nettype none

module h3j_alu (
    input  logic                                   clk,
    input  h3j_pkg::alu_ctrl_t                     ctrl,
    input  logic signed [h3j_pkg::VALUE_BITS-1:0]  rdata,
    input  logic signed [h3j_pkg::GAIN_BITS-1:0]   centre_gain,
    input  logic signed [h3j_pkg::GAIN_BITS-1:0]   neighbour_gain,
    output logic signed [h3j_pkg::VALUE_BITS-1:0]  result
);
    import h3j_pkg::*;

    localparam int QW = ACC_BITS - FRAC_BITS;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic signed [VALUE_BITS-1:0] centre_reg, centre_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [SUM_BITS-1:0]   mul_a;
    logic signed [GAIN_BITS-1:0]  mul_b;
    logic signed [QW-1:0]         q;
    logic [QW-VALUE_BITS:0]       q_hi;

    // single multiplier, operands picked per step
    assign mul_a = ctrl.mul_nb ? sum_reg : SUM_BITS'(centre_reg);
    assign mul_b = ctrl.mul_nb ? neighbour_gain : centre_gain;

    always_comb
    begin
        centre_next = centre_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        if (ctrl.load_centre)
        begin
            centre_next = rdata;
            sum_next    = '0;
        end
        if (ctrl.add_nb)
        begin
            sum_next = sum_reg + SUM_BITS'(rdata);
        end
        if (ctrl.mul_en)
        begin
            prod_next = mul_a * mul_b;
        end
        if (ctrl.acc_init)
        begin
            acc_next = ACC_BITS'(prod_reg) + ROUND_HALF;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + ACC_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        centre_reg <= centre_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
    end

    // floor shift then clamp to the value range
    assign q    = acc_reg[ACC_BITS-1:FRAC_BITS];
    assign q_hi = q[QW-1:VALUE_BITS-1];

    always_comb
    begin
        if ((&q_hi) || !(|q_hi))
        begin
            result = q[VALUE_BITS-1:0];
        end
        else if (q[QW-1])
        begin
            result = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/heat3d_jacobi_stencil_unit.sv =====
// Top level of the 3D heat-equation Jacobi 7-point stencil unit.
// Flow per transfer: IDLE, ISSUE, then RESP; a read inside the grid passes RDATA before RESP,
//   and a run repeats, per sweep, the cell walk in CELL followed by SWAP. Per cell:
//   seven reads on the one source read port, then two passes through the shared multiplier.
// A new transfer is taken only once the last one has left RESP and the FSM is back in IDLE; a
//   finished result may wait in the output register while the next item is worked on.
// Reset clears the FSM, output valid, buffer select and config registers; not the grids.
`default_nettype none

module heat3d_jacobi_stencil_unit #(
    parameter int PADDED_DIM = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  h3j_pkg::req_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output h3j_pkg::resp_t                        out_data,
    input  logic                                  cfg_we,
    input  logic [h3j_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [h3j_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import h3j_pkg::*;

    // Grid address is {z, y, x}, CB bits per axis
    localparam int CB    = $clog2(PADDED_DIM);
    localparam int AW    = 3 * CB;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = ((CB > COORD_BITS) ? CB : COORD_BITS) + 1;
    localparam logic [EW-1:0] EFF_LIM = EW'(PADDED_DIM - 2);

    // ---------------- configuration registers ----------------
    logic [SIZE_BITS-1:0]        size_x_reg, size_y_reg, size_z_reg;
    logic signed [GAIN_BITS-1:0] nb_gain_reg, ctr_gain_reg;
    logic [SWEEP_BITS-1:0]       sweep_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= SIZE_RST;
            size_y_reg      <= SIZE_RST;
            size_z_reg      <= SIZE_RST;
            nb_gain_reg     <= NB_GAIN_RST;
            ctr_gain_reg    <= CTR_GAIN_RST;
            sweep_count_reg <= SWEEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:         size_x_reg      <= cfg_wdata[SIZE_BITS-1:0];
                CFG_SIZE_Y:         size_y_reg      <= cfg_wdata[SIZE_BITS-1:0];
                CFG_SIZE_Z:         size_z_reg      <= cfg_wdata[SIZE_BITS-1:0];
                CFG_NEIGHBOUR_GAIN: nb_gain_reg     <= cfg_wdata[GAIN_BITS-1:0];
                CFG_CENTRE_GAIN:    ctr_gain_reg    <= cfg_wdata[GAIN_BITS-1:0];
                CFG_SWEEP_COUNT:    sweep_count_reg <= cfg_wdata[SWEEP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Effective interior size per axis, clamped to what the grid holds
    logic [EW-1:0] eff_x, eff_y, eff_z;
    logic [CB-1:0] nx, ny, nz;
    logic          interior;

    assign eff_x = (EW'(size_x_reg) > EFF_LIM) ? EFF_LIM : EW'(size_x_reg);
    assign eff_y = (EW'(size_y_reg) > EFF_LIM) ? EFF_LIM : EW'(size_y_reg);
    assign eff_z = (EW'(size_z_reg) > EFF_LIM) ? EFF_LIM : EW'(size_z_reg);
    assign nx    = eff_x[CB-1:0];
    assign ny    = eff_y[CB-1:0];
    assign nz    = eff_z[CB-1:0];
    // an axis of size zero has no interior, so a sweep is only a buffer swap
    assign interior = (nx != '0) && (ny != '0) && (nz != '0);

    // ---------------- control and item registers ----------------
    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [CB-1:0]         cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [SWEEP_BITS-1:0] sweep_reg, sweep_next;
    logic                  newest_reg, newest_next;   // 1: odd buffer is newest
    logic                  out_valid_reg, out_valid_next;
    req_t                  req_reg, req_next;
    resp_t                 res_reg, res_next;
    resp_t                 out_data_reg, out_data_next;

    // Request address and bounds check
    logic [CB+COORD_BITS-1:0] rx_w, ry_w, rz_w;
    logic [AW-1:0]            req_addr;
    logic                     req_inside;
    logic                     req_is_access;

    assign rx_w     = {{CB{1'b0}}, req_reg.coord_x};
    assign ry_w     = {{CB{1'b0}}, req_reg.coord_y};
    assign rz_w     = {{CB{1'b0}}, req_reg.coord_z};
    assign req_addr = {rz_w[CB-1:0], ry_w[CB-1:0], rx_w[CB-1:0]};

    assign req_inside = (EW'(req_reg.coord_x) <= eff_x + EW'(1))
                     && (EW'(req_reg.coord_y) <= eff_y + EW'(1))
                     && (EW'(req_reg.coord_z) <= eff_z + EW'(1));
    assign req_is_access = (req_reg.req_type == REQ_WRITE)
                        || (req_reg.req_type == REQ_READ);

    // Stencil walk: centre and six face neighbors of the current cell
    logic [CB-1:0] nbx, nby, nbz;
    logic [AW-1:0] cell_raddr, cell_waddr;
    logic          last_cell;
    logic [SWEEP_BITS-1:0] sweep_inc;

    always_comb
    begin
        nbx = cx_reg;
        nby = cy_reg;
        nbz = cz_reg;
        unique case (phase_reg)
            PH_RD_XM: nbx = cx_reg - CB'(1);
            PH_RD_XP: nbx = cx_reg + CB'(1);
            PH_RD_YM: nby = cy_reg - CB'(1);
            PH_RD_YP: nby = cy_reg + CB'(1);
            PH_RD_ZM: nbz = cz_reg - CB'(1);
            PH_RD_ZP: nbz = cz_reg + CB'(1);
            default:  ;
        endcase
    end

    assign cell_raddr = {nbz, nby, nbx};
    assign cell_waddr = {cz_reg, cy_reg, cx_reg};
    assign last_cell  = (cx_reg == nx) && (cy_reg == ny) && (cz_reg == nz);
    assign sweep_inc  = sweep_reg + SWEEP_BITS'(1);

    // ---------------- grid buffers ----------------
    logic                  we_even, we_odd;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [VALUE_BITS-1:0] even_rdata, odd_rdata;
    logic signed [VALUE_BITS-1:0] src_rdata;
    logic signed [VALUE_BITS-1:0] alu_result;
    alu_ctrl_t             alu_ctrl;
    logic                  resp_fire;

    h3j_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_grid_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (even_rdata)
    );

    h3j_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_grid_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (odd_rdata)
    );

    // sweeps and reads both take data from the newest buffer
    assign src_rdata = newest_reg ? odd_rdata : even_rdata;

    h3j_alu u_alu (
        .clk            (clk),
        .ctrl           (alu_ctrl),
        .rdata          (src_rdata),
        .centre_gain    (ctr_gain_reg),
        .neighbour_gain (nb_gain_reg),
        .result         (alu_result)
    );

    // ---------------- FSM: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                unique case (req_reg.req_type)
                    REQ_READ:
                    begin
                        state_next = req_inside ? ST_RDATA : ST_RESP;
                    end
                    REQ_RUN:
                    begin
                        if (sweep_count_reg == '0)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = interior ? ST_CELL : ST_SWAP;
                        end
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_RDATA: state_next = ST_RESP;
            ST_CELL:
            begin
                if ((phase_reg == PH_WB) && last_cell)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                if (sweep_inc == sweep_count_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = interior ? ST_CELL : ST_SWAP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- FSM: outputs ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        we_even   = 1'b0;
        we_odd    = 1'b0;
        waddr     = req_addr;
        wdata     = req_reg.cell_value;
        raddr     = req_addr;
        resp_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_ISSUE:
            begin
                // a write lands in both buffers
                if ((req_reg.req_type == REQ_WRITE) && req_inside)
                begin
                    we_even = 1'b1;
                    we_odd  = 1'b1;
                end
            end
            ST_CELL:
            begin
                raddr = cell_raddr;
                waddr = cell_waddr;
                wdata = alu_result;
                if (phase_reg == PH_WB)
                begin
                    we_even = newest_reg;
                    we_odd  = !newest_reg;
                end
            end
            ST_RESP: resp_fire = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Stencil step decode for the shared unit
    always_comb
    begin
        alu_ctrl = '0;
        if (state_reg == ST_CELL)
        begin
            unique case (phase_reg) inside
                PH_RD_XM: alu_ctrl.load_centre = 1'b1;
                PH_RD_XP, PH_RD_YM, PH_RD_YP, PH_RD_ZM, PH_RD_ZP, PH_LAST_NB:
                    alu_ctrl.add_nb = 1'b1;
                PH_MUL_C: alu_ctrl.mul_en = 1'b1;
                PH_MUL_N:
                begin
                    alu_ctrl.mul_en   = 1'b1;
                    alu_ctrl.mul_nb   = 1'b1;
                    alu_ctrl.acc_init = 1'b1;
                end
                PH_ACC:   alu_ctrl.acc_add = 1'b1;
                default:  ;
            endcase
        end
    end

    // ---------------- register next values ----------------
    always_comb
    begin
        phase_next    = phase_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        sweep_next    = sweep_reg;
        newest_next   = newest_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        out_data_next = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                end
            end
            ST_ISSUE:
            begin
                res_next          = '0;
                res_next.status   = req_is_access && !req_inside;
                res_next.run_done = (req_reg.req_type == REQ_RUN);
                sweep_next        = '0;
                cx_next           = CB'(1);
                cy_next           = CB'(1);
                cz_next           = CB'(1);
                phase_next        = PH_RD_C;
            end
            ST_RDATA: res_next.read_value = src_rdata;
            ST_CELL:
            begin
                if (phase_reg == PH_WB)
                begin
                    phase_next = PH_RD_C;
                    // raster order: x fastest, then y, then z
                    if (cx_reg == nx)
                    begin
                        cx_next = CB'(1);
                        if (cy_reg == ny)
                        begin
                            cy_next = CB'(1);
                            cz_next = cz_reg + CB'(1);
                        end
                        else
                        begin
                            cy_next = cy_reg + CB'(1);
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + CB'(1);
                    end
                end
                else
                begin
                    phase_next = phase_t'(4'(phase_reg) + 4'd1);
                end
            end
            ST_SWAP:
            begin
                newest_next = !newest_reg;
                sweep_next  = sweep_inc;
                cx_next     = CB'(1);
                cy_next     = CB'(1);
                cz_next     = CB'(1);
                phase_next  = PH_RD_C;
            end
            ST_RESP:
            begin
                if (resp_fire)
                begin
                    out_data_next = res_reg;
                end
            end
            default: ;
        endcase
    end

    // output register frees the FSM while a result waits for its transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (resp_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_RD_C;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            sweep_reg     <= '0;
            newest_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cz_reg        <= cz_next;
            sweep_reg     <= sweep_next;
            newest_reg    <= newest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== verif/stencil_checker.sv =====
// Checker for the 3D Jacobi stencil unit: predicts each result and compares it with the DUT.
`timescale 1ns / 100ps

module stencil_checker
    import h3j_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  req_t                       in_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  resp_t                      out_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
    output int                         errors,
    output int                         pending,
    output int                         checked
);

    localparam int     PAD       = 32;
    localparam int     PAD_CELLS = PAD * PAD * PAD;
    localparam longint VMAX      = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN      = -VMAX - 1;

    int grid_even [0:PAD_CELLS-1];
    int grid_odd  [0:PAD_CELLS-1];
    bit newest_odd = 1'b0;

    logic [SIZE_BITS-1:0]  size_x = SIZE_RST;
    logic [SIZE_BITS-1:0]  size_y = SIZE_RST;
    logic [SIZE_BITS-1:0]  size_z = SIZE_RST;
    int                    neighbour_gain = NB_GAIN_RST;
    int                    centre_gain = CTR_GAIN_RST;
    logic [SWEEP_BITS-1:0] sweep_count = SWEEP_RST;

    resp_t resp_expect_q [$];
    int    err_count = 0;
    int    check_count = 0;
    int    expect_count = 0;

    assign errors  = err_count;
    assign pending = expect_count;
    assign checked = check_count;

    function automatic int unsigned active_cells(input logic [SIZE_BITS-1:0] s);
        return (s > PAD - 2) ? PAD - 2 : s;
    endfunction

    function automatic int unsigned cell_addr(input int unsigned x, y, z);
        return (z * PAD + y) * PAD + x;
    endfunction

    function automatic longint src_cell(input int unsigned i);
        return newest_odd ? longint'(grid_odd[i]) : longint'(grid_even[i]);
    endfunction

    // One sweep: interior of the other buffer from the newest one, then swap.
    function automatic void sweep_grid();
        int unsigned nx, ny, nz, i;
        longint      nsum, acc, q;
        nx = active_cells(size_x);
        ny = active_cells(size_y);
        nz = active_cells(size_z);
        for (int unsigned z = 1; z <= nz; z++)
            for (int unsigned y = 1; y <= ny; y++)
                for (int unsigned x = 1; x <= nx; x++)
                begin
                    i    = cell_addr(x, y, z);
                    nsum = src_cell(i - 1) + src_cell(i + 1) + src_cell(i - PAD)
                         + src_cell(i + PAD) + src_cell(i - PAD * PAD)
                         + src_cell(i + PAD * PAD);
                    acc  = longint'(centre_gain) * src_cell(i)
                         + longint'(neighbour_gain) * nsum;
                    // round half up, then clamp to the value range
                    q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                    if (q > VMAX)
                        q = VMAX;
                    else if (q < VMIN)
                        q = VMIN;
                    if (newest_odd)
                        grid_even[i] = int'(q);
                    else
                        grid_odd[i] = int'(q);
                end
        newest_odd = !newest_odd;
    endfunction

    function automatic resp_t predict_resp(input req_t r);
        resp_t       res;
        int unsigned i;
        res = '0;
        case (r.req_type)
            REQ_WRITE, REQ_READ:
            begin
                if (r.coord_x > active_cells(size_x) + 1 || r.coord_y > active_cells(size_y) + 1
                    || r.coord_z > active_cells(size_z) + 1)
                    res.status = 1'b1;
                else
                begin
                    i = cell_addr(r.coord_x, r.coord_y, r.coord_z);
                    if (r.req_type == REQ_WRITE)
                    begin
                        grid_even[i] = r.cell_value;
                        grid_odd[i]  = r.cell_value;
                    end
                    else
                        res.read_value = newest_odd ? grid_odd[i] : grid_even[i];
                end
            end
            REQ_RUN:
            begin
                for (int s = 0; s < int'(sweep_count); s++)
                    sweep_grid();
                res.run_done = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x         = SIZE_RST;
            size_y         = SIZE_RST;
            size_z         = SIZE_RST;
            neighbour_gain = NB_GAIN_RST;
            centre_gain    = CTR_GAIN_RST;
            sweep_count    = SWEEP_RST;
            newest_odd     = 1'b0;
            resp_expect_q.delete();
            expect_count   = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_SIZE_X:         size_x = cfg_wdata[SIZE_BITS-1:0];
                    CFG_SIZE_Y:         size_y = cfg_wdata[SIZE_BITS-1:0];
                    CFG_SIZE_Z:         size_z = cfg_wdata[SIZE_BITS-1:0];
                    CFG_NEIGHBOUR_GAIN: neighbour_gain = $signed(cfg_wdata[GAIN_BITS-1:0]);
                    CFG_CENTRE_GAIN:    centre_gain = $signed(cfg_wdata[GAIN_BITS-1:0]);
                    CFG_SWEEP_COUNT:    sweep_count = cfg_wdata[SWEEP_BITS-1:0];
                    default: ;
                endcase

            if (in_valid && in_ready)
                resp_expect_q.push_back(predict_resp(in_data));

            if (out_valid && out_ready)
            begin
                if (resp_expect_q.size() == 0)
                begin
                    $display("%0t: result with none expected, got %h", $time, out_data);
                    err_count++;
                end
                else
                begin
                    resp_t exp_r;
                    exp_r = resp_expect_q.pop_front();
                    check_count++;
                    if (out_data.read_value !== exp_r.read_value)
                    begin
                        $display("%0t: read_value expected %h, got %h", $time,
                                 exp_r.read_value, out_data.read_value);
                        err_count++;
                    end
                    if (out_data.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %b, got %b", $time,
                                 exp_r.status, out_data.status);
                        err_count++;
                    end
                    if (out_data.run_done !== exp_r.run_done)
                    begin
                        $display("%0t: run_done expected %b, got %b", $time,
                                 exp_r.run_done, out_data.run_done);
                        err_count++;
                    end
                end
            end
            expect_count = resp_expect_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the 3D Jacobi stencil unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;

    import h3j_pkg::*;

    localparam int PAD            = 32;
    localparam int IDLE_PCT       = 23;      // percent of cycles a side holds off
    // Longest quiet stretch: one run of 65535 sweeps over an empty axis, each sweep
    // only a buffer swap, plus output stalls; taken a few times over.
    localparam int WATCHDOG_LIMIT = 250000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    req_t  in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    resp_t out_data;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    int errors;
    int pending;
    int checked;

    // Stimulus-side view of the grid: which cells hold a written value, and
    // the highest padded coordinate per axis under the current sizes.
    bit          written [0:PAD*PAD*PAD-1];
    int unsigned lim_x = PAD - 1;
    int unsigned lim_y = PAD - 1;
    int unsigned lim_z = PAD - 1;
    bit          calm = 1'b0;   // no hold-off on either side while set

    int n_write = 0;
    int n_read = 0;
    int n_run = 0;
    int n_none = 0;
    int n_cfg = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    heat3d_jacobi_stencil_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stencil_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int unsigned cell_addr(input int unsigned x, y, z);
        return (z * PAD + y) * PAD + x;
    endfunction

    function automatic bit in_grid(input req_t r);
        return r.coord_x <= lim_x && r.coord_y <= lim_y && r.coord_z <= lim_z;
    endfunction

    function automatic req_t mk_req(input req_type_t t, input int unsigned x, y, z,
                                    input logic [VALUE_BITS-1:0] v);
        req_t r;
        r.req_type   = t;
        r.coord_x    = COORD_BITS'(x);
        r.coord_y    = COORD_BITS'(y);
        r.coord_z    = COORD_BITS'(z);
        r.cell_value = v;
        return r;
    endfunction

    // Cell values: extremes now and then, mostly small Q16.16 or raw random.
    function automatic logic [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3, 4, 5: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] rand_gain();
        case ($urandom_range(7))
            0:       return 18'h20000;
            1:       return 18'h1ffff;
            2, 3:    return 18'($urandom_range(0, 262143));
            default: return 18'($urandom_range(0, 32768)) - 18'd16384;
        endcase
    endfunction

    // One input transfer. Optional hold-off first; ready is looked at mid-cycle
    // so the transfer lands on the following rising edge.
    task automatic send_req(input req_t r);
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_data  <= r;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        case (r.req_type)
            REQ_WRITE:
            begin
                n_write++;
                if (in_grid(r))
                    written[cell_addr(r.coord_x, r.coord_y, r.coord_z)] = 1'b1;
            end
            REQ_READ: n_read++;
            REQ_RUN:  n_run++;
            default:  n_none++;
        endcase
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Full register set, written only with the block idle.
    task automatic load_config(input int sx, sy, sz,
                               input logic [GAIN_BITS-1:0] nb, ctr, input int sweeps);
        drain_results();
        write_reg(CFG_SIZE_X, CFG_DATA_BITS'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_BITS'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_BITS'(sz));
        write_reg(CFG_NEIGHBOUR_GAIN, nb);
        write_reg(CFG_CENTRE_GAIN, ctr);
        write_reg(CFG_SWEEP_COUNT, CFG_DATA_BITS'(sweeps));
        cfg_we <= 1'b0;
        // sizes above the interior maximum behave as the maximum
        lim_x = ((sx > PAD - 2) ? PAD - 2 : sx) + 1;
        lim_y = ((sy > PAD - 2) ? PAD - 2 : sy) + 1;
        lim_z = ((sz > PAD - 2) ? PAD - 2 : sz) + 1;
        n_cfg++;
    endtask

    // A run may only touch written cells: write whatever of the padded grid is
    // still unwritten.
    task automatic fill_grid();
        for (int unsigned z = 0; z <= lim_z; z++)
            for (int unsigned y = 0; y <= lim_y; y++)
                for (int unsigned x = 0; x <= lim_x; x++)
                    if (!written[cell_addr(x, y, z)])
                        send_req(mk_req(REQ_WRITE, x, y, z, rand_value()));
    endtask

    // Mostly in-grid writes, reads and runs on a filled grid; the rest is
    // unused requests and accesses outside the grid.
    task automatic run_random(input int count, input int max_runs);
        int   runs_left;
        int   pick;
        int   axis;
        req_t r;
        runs_left = max_runs;
        for (int k = 0; k < count; k++)
        begin
            // now and then hold the sender until the block has emptied
            if ($urandom_range(49) == 0)
                drain_results();
            pick = $urandom_range(99);
            r = mk_req(REQ_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 31), rand_value());
            if (pick < 87 && (pick < 77 || runs_left == 0))
            begin
                r.req_type = (pick < 40) ? REQ_WRITE : REQ_READ;
                if ($urandom_range(99) < 85)
                begin
                    r.coord_x = COORD_BITS'($urandom_range(0, lim_x));
                    r.coord_y = COORD_BITS'($urandom_range(0, lim_y));
                    r.coord_z = COORD_BITS'($urandom_range(0, lim_z));
                end
            end
            else if (pick < 87)
            begin
                r.req_type = REQ_RUN;
                runs_left--;
            end
            else if (pick >= 92)
            begin
                // push one axis past the padded grid
                r.req_type = pick[0] ? REQ_WRITE : REQ_READ;
                axis = $urandom_range(2);
                if (axis == 0 && lim_x < 31)
                    r.coord_x = COORD_BITS'($urandom_range(lim_x + 1, 31));
                else if (axis == 1 && lim_y < 31)
                    r.coord_y = COORD_BITS'($urandom_range(lim_y + 1, 31));
                else if (lim_z < 31)
                    r.coord_z = COORD_BITS'($urandom_range(lim_z + 1, 31));
            end
            send_req(r);
        end
    endtask

    initial
    begin
        int sx;
        int sy;
        int sz;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: whole 32^3 padded grid addressable, corners and raw
        // value extremes, plus the unused request type.
        send_req(mk_req(REQ_WRITE, 0, 0, 0, 32'h8000_0000));
        send_req(mk_req(REQ_WRITE, 31, 31, 31, 32'h7fff_ffff));
        send_req(mk_req(REQ_WRITE, 31, 0, 5, 32'h0000_0000));
        send_req(mk_req(REQ_READ, 0, 0, 0, 32'hffff_ffff));
        send_req(mk_req(REQ_READ, 31, 31, 31, 32'h0000_0000));
        send_req(mk_req(REQ_READ, 31, 0, 5, $urandom()));
        send_req(mk_req(REQ_NONE, 31, 31, 31, 32'hffff_ffff));
        send_req(mk_req(REQ_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom()));

        // Single interior cell, gentle gains.
        load_config(1, 1, 1, 18'd16384, 18'd32768, 1);
        fill_grid();
        send_req(mk_req(REQ_RUN, 31, 31, 31, 32'hffff_ffff));
        send_req(mk_req(REQ_READ, 1, 1, 1, 0));
        send_req(mk_req(REQ_READ, 0, 1, 1, 0));          // padding keeps its value
        send_req(mk_req(REQ_WRITE, 3, 1, 1, 32'h1234_5678)); // outside: dropped
        send_req(mk_req(REQ_READ, 1, 3, 1, 0));
        send_req(mk_req(REQ_READ, 1, 1, 31, 0));
        send_req(mk_req(REQ_WRITE, 1, 1, 1, 32'hffff_ffff));
        send_req(mk_req(REQ_RUN, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 1, 1, 1, 0));
        send_req(mk_req(REQ_READ, 3, 0, 0, 0));

        // Empty x axis with the largest sweep count: every sweep only swaps.
        load_config(0, 2, 3, rand_gain(), rand_gain(), 65535);
        fill_grid();
        send_req(mk_req(REQ_RUN, 0, 0, 0, 0));
        run_random(30, 0);

        // Widest x, most negative neighbor gain, largest centre gain.
        load_config(30, 1, 1, 18'h20000, 18'h1ffff, 2);
        fill_grid();
        run_random(40, 3);

        // Oversized y acts as full size; zero sweeps leave the grid alone.
        load_config(1, 31, 1, 18'h1ffff, 18'h20000, 0);
        fill_grid();
        run_random(40, 4);

        load_config(1, 1, 30, rand_gain(), rand_gain(), 1);
        fill_grid();
        run_random(40, 3);

        // Small random grids; two phases run without any hold-off.
        for (int p = 0; p < 8; p++)
        begin
            sx = $urandom_range(1, 3);
            sy = $urandom_range(1, 3);
            sz = $urandom_range(1, 3);
            if ($urandom_range(3) == 0)
                case ($urandom_range(2))
                    0:       sx = $urandom_range(0, 4);
                    1:       sy = $urandom_range(0, 4);
                    default: sz = $urandom_range(0, 4);
                endcase
            load_config(sx, sy, sz, rand_gain(), rand_gain(), $urandom_range(0, 3));
            calm = (p == 3 || p == 4);
            fill_grid();
            run_random(50, 8);
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d transfers: %0d writes, %0d reads, %0d runs, %0d unused requests",
                 n_write + n_read + n_run + n_none, n_write, n_read, n_run, n_none);
        $display("%0d register settings (sizes 0 to 31, gain extremes, up to 65535 sweeps), %0d results checked",
                 n_cfg, checked);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
